// ===== hdl/half_float_error_metrics_unit_assert.svh =====
// Assertion macros used by the checker file of the error metrics unit.
`ifndef HALF_FLOAT_ERROR_METRICS_UNIT_ASSERT_SVH
`define HALF_FLOAT_ERROR_METRICS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HFEM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HFEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hfem_pkg.sv =====
// Shared types, widths, field offsets and helper functions of the error metrics unit.
package hfem_pkg;

  localparam int COUNT_WIDTH = 48;
  localparam int HALF_W      = 16;
  localparam int ERR_W       = 41;
  localparam int TOL_W       = 41;
  localparam int SUM_W       = 64;
  localparam int OUT_CNT_W   = 48;
  localparam int LO_W        = 24;
  localparam int HI_W        = ERR_W - LO_W;

  localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(16777);
  localparam logic [4:0]       EXP_SPECIAL = 5'd31;

  // input item: reference, candidate, restart
  localparam int IN_OFS_REF     = 0;
  localparam int IN_OFS_CAND    = IN_OFS_REF + HALF_W;
  localparam int IN_OFS_RESTART = IN_OFS_CAND + HALF_W;
  localparam int IN_USED_W      = IN_OFS_RESTART + 1;
  localparam int IN_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;

  // result item
  localparam int OFS_SEEN    = 0;
  localparam int OFS_NONFIN  = OFS_SEEN + OUT_CNT_W;
  localparam int OFS_OVER    = OFS_NONFIN + OUT_CNT_W;
  localparam int OFS_SUM     = OFS_OVER + OUT_CNT_W;
  localparam int OFS_PEAK    = OFS_SUM + SUM_W;
  localparam int OFS_ERR     = OFS_PEAK + ERR_W;
  localparam int OFS_PAD     = OFS_ERR + ERR_W;
  localparam int OUT_TDATA_W = ((OFS_PAD + 7) / 8) * 8;

  typedef logic [ERR_W-1:0]       err_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [SUM_W-1:0]       sum_t;

  typedef struct packed {
    logic restart;
    logic nonfinite;
  } tag_t;

  // exact magnitude of a finite half in 2^-24 units
  function automatic err_t half_mag(input logic [HALF_W-1:0] h);
    logic [4:0] x;
    err_t       mag;
    x = h[14:10];
    if (x == 5'd0) begin
      mag = ERR_W'(h[9:0]);
    end else begin
      mag = ERR_W'({1'b1, h[9:0]}) << (x - 5'd1);
    end
    return mag;
  endfunction

  function automatic logic is_special(input logic [HALF_W-1:0] h);
    return h[14:10] == EXP_SPECIAL;
  endfunction

  // low bits of a counter as shown on the result item
  function automatic logic [OUT_CNT_W-1:0] cnt_view(input cnt_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

// ===== hdl/hfem_decode.sv =====
// Decode stage: both halves to fixed point, absolute error and nonfinite flag.
module hfem_decode (
  input  logic                               clk,
  input  logic                               en,
  input  logic [hfem_pkg::HALF_W-1:0]        ref_half,
  input  logic [hfem_pkg::HALF_W-1:0]        cand_half,
  input  logic                               restart,
  output hfem_pkg::err_t                     err_r,
  output hfem_pkg::tag_t                     tag_r
);
  import hfem_pkg::*;

  err_t ma;
  err_t mb;
  err_t err_nxt;
  tag_t tag_nxt;

  assign ma = half_mag(ref_half);
  assign mb = half_mag(cand_half);

  always_comb begin
    tag_nxt.restart   = restart;
    tag_nxt.nonfinite = is_special(ref_half) | is_special(cand_half);
    if (tag_nxt.nonfinite) begin
      err_nxt = '0;
    end else if (ref_half[HALF_W-1] != cand_half[HALF_W-1]) begin
      err_nxt = ma + mb;
    end else if (ma >= mb) begin
      err_nxt = ma - mb;
    end else begin
      err_nxt = mb - ma;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_r <= err_nxt;
      tag_r <= tag_nxt;
    end
  end

endmodule

// ===== hdl/hfem_square.sv =====
// Two-stage scaled square: partial products, then floor(d*d / 2^24).
module hfem_square (
  input  logic           clk,
  input  logic           en_mul,
  input  logic           en_sq,
  input  hfem_pkg::err_t err_in,
  input  hfem_pkg::tag_t tag_in,
  output hfem_pkg::sum_t sq_r,
  output hfem_pkg::err_t err_r,
  output hfem_pkg::tag_t tag_r
);
  import hfem_pkg::*;

  logic [HI_W-1:0]        hi;
  logic [LO_W-1:0]        lo;
  logic [2*HI_W-1:0]      hh_nxt, hh_r;
  logic [HI_W+LO_W-1:0]   hl_nxt, hl_r;
  logic [2*LO_W-1:0]      ll_nxt, ll_r;
  err_t                   err_m_r;
  tag_t                   tag_m_r;
  sum_t                   sq_nxt;

  assign hi = err_in[ERR_W-1:LO_W];
  assign lo = err_in[LO_W-1:0];

  assign hh_nxt = (2*HI_W)'(hi) * (2*HI_W)'(hi);
  assign hl_nxt = (HI_W+LO_W)'(hi) * (HI_W+LO_W)'(lo);
  assign ll_nxt = (2*LO_W)'(lo) * (2*LO_W)'(lo);

  // hi^2 * 2^24 + 2*hi*lo + floor(lo^2 / 2^24)
  assign sq_nxt = (SUM_W'(hh_r) << LO_W) + (SUM_W'(hl_r) << 1) + SUM_W'(ll_r >> LO_W);

  always_ff @(posedge clk) begin
    if (en_mul) begin
      hh_r    <= hh_nxt;
      hl_r    <= hl_nxt;
      ll_r    <= ll_nxt;
      err_m_r <= err_in;
      tag_m_r <= tag_in;
    end
    if (en_sq) begin
      sq_r  <= sq_nxt;
      err_r <= err_m_r;
      tag_r <= tag_m_r;
    end
  end

endmodule

// ===== hdl/hfem_accum.sv =====
// Running totals: saturating counters, saturating square sum and peak error.
module hfem_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  hfem_pkg::sum_t            sq,
  input  hfem_pkg::err_t            err,
  input  hfem_pkg::tag_t            tag,
  input  logic [hfem_pkg::TOL_W-1:0] tol,
  output hfem_pkg::cnt_t            seen_r,
  output hfem_pkg::cnt_t            nonfin_r,
  output hfem_pkg::cnt_t            over_r,
  output hfem_pkg::sum_t            sum_r,
  output hfem_pkg::err_t            peak_r,
  output hfem_pkg::err_t            pair_err_r,
  output logic                      pair_nf_r
);
  import hfem_pkg::*;

  localparam cnt_t CNT_MAX = '1;

  cnt_t             seen_base, nonfin_base, over_base;
  sum_t             sum_base;
  err_t             peak_base;
  cnt_t             seen_nxt, nonfin_nxt, over_nxt;
  sum_t             sum_nxt;
  err_t             peak_nxt;
  logic [SUM_W:0]   sum_wide;
  logic             over_hit;

  function automatic cnt_t cnt_inc(input cnt_t c);
    return (c == CNT_MAX) ? c : c + cnt_t'(1);
  endfunction

  // restart clears the totals before this item is counted
  assign seen_base   = tag.restart ? '0 : seen_r;
  assign nonfin_base = tag.restart ? '0 : nonfin_r;
  assign over_base   = tag.restart ? '0 : over_r;
  assign sum_base    = tag.restart ? '0 : sum_r;
  assign peak_base   = tag.restart ? '0 : peak_r;

  assign over_hit = !tag.nonfinite && (TOL_W'(err) > tol);
  assign sum_wide = {1'b0, sum_base} + {1'b0, sq};

  always_comb begin
    seen_nxt   = cnt_inc(seen_base);
    nonfin_nxt = tag.nonfinite ? cnt_inc(nonfin_base) : nonfin_base;
    over_nxt   = over_hit ? cnt_inc(over_base) : over_base;
    sum_nxt    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    peak_nxt   = (err > peak_base) ? err : peak_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      nonfin_r <= '0;
      over_r   <= '0;
      sum_r    <= '0;
      peak_r   <= '0;
    end else if (en) begin
      seen_r   <= seen_nxt;
      nonfin_r <= nonfin_nxt;
      over_r   <= over_nxt;
      sum_r    <= sum_nxt;
      peak_r   <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair_err_r <= err;
      pair_nf_r  <= tag.nonfinite;
    end
  end

endmodule

// ===== hdl/half_float_error_metrics_unit.sv =====
// Top level of the binary16 pairwise error metrics unit.
//
// Input channel (in_*): one item is a pair of raw binary16 patterns plus a
// restart flag; restart clears every running total before the pair counts.
// Result channel (out_*): one item per input item, carrying the running
// counters, the saturating square sum, the peak error and this pair's error;
// out_tuser flags a pair skipped as nonfinite (infinity or NaN member).
// Configuration: cfg_we writes cfg_wdata into the error tolerance (2^-24
// units) at the clock edge; write it only while no item is in flight.
// Path: an accepted input item passes the input register, decode, partial
// products, square and result register before its result appears.
// Throughput: one item per cycle while out_tready stays high; the only loop
// is the update of the totals in the result stage.
// Reset (rst_n low, synchronous): all stage valids and totals clear, the
// tolerance returns to 16777 (about 0.001).
// Stall: while out_tready is low the result holds; bubbles in the pipe still
// close up, so in_tready drops only once every stage holds an item.
module half_float_error_metrics_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // reference_half, candidate_half, restart, zero pad
  input  logic [hfem_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // values_seen, nonfinite_count, over_tolerance, squared_error_sum,
  // largest_error, pair_error, zero pad
  output logic [hfem_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // pair_nonfinite
  output logic                                out_tuser,
  input  logic                                cfg_we,
  input  logic [hfem_pkg::TOL_W-1:0]          cfg_wdata
);
  import hfem_pkg::*;

  // stage valids, input stage first
  logic in_v_r, dec_v_r, mul_v_r, sq_v_r, out_v_r;
  // a stage may load when empty or when its contents move on
  logic rdy_in, rdy_dec, rdy_mul, rdy_sq, rdy_out;

  logic [HALF_W-1:0] ref_half_r;
  logic [HALF_W-1:0] cand_half_r;
  logic              restart_r;
  logic [TOL_W-1:0]  tol_r;

  err_t dec_err;
  tag_t dec_tag;
  sum_t sq_val;
  err_t sq_err;
  tag_t sq_tag;

  cnt_t seen, nonfin, over;
  sum_t sum;
  err_t peak;
  err_t pair_err;
  logic pair_nf;

  assign rdy_out = !out_v_r || out_tready;
  assign rdy_sq  = !sq_v_r  || rdy_out;
  assign rdy_mul = !mul_v_r || rdy_sq;
  assign rdy_dec = !dec_v_r || rdy_mul;
  assign rdy_in  = !in_v_r  || rdy_dec;

  assign in_tready  = rdy_in;
  assign out_tvalid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      dec_v_r <= 1'b0;
      mul_v_r <= 1'b0;
      sq_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      tol_r   <= TOL_RESET;
    end else begin
      if (rdy_in)  in_v_r  <= in_tvalid;
      if (rdy_dec) dec_v_r <= in_v_r;
      if (rdy_mul) mul_v_r <= dec_v_r;
      if (rdy_sq)  sq_v_r  <= mul_v_r;
      if (rdy_out) out_v_r <= sq_v_r;
      if (cfg_we)  tol_r   <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rdy_in) begin
      ref_half_r  <= in_tdata[IN_OFS_REF +: HALF_W];
      cand_half_r <= in_tdata[IN_OFS_CAND +: HALF_W];
      restart_r   <= in_tdata[IN_OFS_RESTART];
    end
  end

  hfem_decode u_decode (
    .clk       (clk),
    .en        (rdy_dec),
    .ref_half  (ref_half_r),
    .cand_half (cand_half_r),
    .restart   (restart_r),
    .err_r     (dec_err),
    .tag_r     (dec_tag)
  );

  hfem_square u_square (
    .clk    (clk),
    .en_mul (rdy_mul),
    .en_sq  (rdy_sq),
    .err_in (dec_err),
    .tag_in (dec_tag),
    .sq_r   (sq_val),
    .err_r  (sq_err),
    .tag_r  (sq_tag)
  );

  // totals double as the result register; they move only when an item enters
  hfem_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (rdy_out && sq_v_r),
    .sq         (sq_val),
    .err        (sq_err),
    .tag        (sq_tag),
    .tol        (tol_r),
    .seen_r     (seen),
    .nonfin_r   (nonfin),
    .over_r     (over),
    .sum_r      (sum),
    .peak_r     (peak),
    .pair_err_r (pair_err),
    .pair_nf_r  (pair_nf)
  );

  assign out_tdata = {{(OUT_TDATA_W-OFS_PAD){1'b0}}, pair_err, peak, sum,
                      cnt_view(over), cnt_view(nonfin), cnt_view(seen)};
  assign out_tuser = pair_nf;

endmodule

// ===== hdl/hfem_checker.sv =====
// Port-level checker for the error metrics unit, bound to the top level.
`include "half_float_error_metrics_unit_assert.svh"

module hfem_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hfem_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import hfem_pkg::*;

  logic                 out_stall;
  logic [OUT_TDATA_W:0] out_word;
  logic [ERR_W-1:0]     out_err;
  logic [ERR_W-1:0]     out_peak;
  logic [OUT_CNT_W-1:0] out_seen;

  assign out_stall = out_tvalid && !out_tready;
  assign out_word  = {out_tuser, out_tdata};
  assign out_err   = out_tdata[OFS_ERR +: ERR_W];
  assign out_peak  = out_tdata[OFS_PEAK +: ERR_W];
  assign out_seen  = out_tdata[OFS_SEEN +: OUT_CNT_W];

  // stalled result must hold
  `HFEM_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_word), "stalled result changed")

  // a skipped pair reports zero error
  `HFEM_ASSERT_SAME(a_nonfin_zero, out_tvalid && out_tuser, out_err == '0, "nonfinite pair with error")

  // peak tracks every finite error
  `HFEM_ASSERT_SAME(a_peak_bound, out_tvalid, out_err <= out_peak, "pair error above peak error")

  // every result counts at least its own pair
  `HFEM_ASSERT_SAME(a_seen_nonzero, out_tvalid, out_seen != '0, "result with zero pair count")

  // input blocks only behind a stalled result
  `HFEM_ASSERT_SAME(a_in_block, !in_tready, out_stall, "input blocked without a stall")

endmodule

bind half_float_error_metrics_unit hfem_checker u_hfem_checker (.*);

// ===== verif/half_float_error_metrics_unit_tb.sv =====
// Self-checking testbench for the binary16 pairwise error metrics unit.
module half_float_error_metrics_unit_tb;
  import hfem_pkg::*;

  // One result item as predicted, fields in the order they sit in out_tdata.
  typedef struct packed {
    logic [OUT_CNT_W-1:0] seen;
    logic [OUT_CNT_W-1:0] nonfin;
    logic [OUT_CNT_W-1:0] over;
    logic [SUM_W-1:0]     sq_sum;
    logic [ERR_W-1:0]     peak;
    logic [ERR_W-1:0]     err;
    logic                 nonfinite;
  } metrics_t;

  // Scoreboard: keeps its own copy of the running totals and the tolerance,
  // predicts the metrics for every accepted pair and checks results in order.
  class metrics_scoreboard;
    metrics_t               expected_q[$];
    logic [TOL_W-1:0]       tolerance;
    logic [COUNT_WIDTH-1:0] pair_cnt;
    logic [COUNT_WIDTH-1:0] nonfin_cnt;
    logic [COUNT_WIDTH-1:0] over_cnt;
    logic [SUM_W-1:0]       sq_acc;
    logic [ERR_W-1:0]       peak_err;
    int                     fails;
    int                     reported;

    function new();
      tolerance = TOL_W'(16777);
      clear_totals();
      fails = 0;
      reported = 0;
    endfunction

    function void clear_totals();
      pair_cnt   = '0;
      nonfin_cnt = '0;
      over_cnt   = '0;
      sq_acc     = '0;
      peak_err   = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_tolerance(input logic [TOL_W-1:0] v);
      tolerance = v;
    endfunction

    // exact unsigned magnitude of a finite half, 2^-24 units
    function logic [ERR_W-1:0] decode_half(input logic [HALF_W-1:0] h);
      logic [4:0] e;
      e = h[14:10];
      if (e == 5'd0) return ERR_W'(h[9:0]);
      return ERR_W'({1'b1, h[9:0]}) << (e - 5'd1);
    endfunction

    function logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void note_pair(input logic [HALF_W-1:0] a, input logic [HALF_W-1:0] b,
                            input logic restart);
      metrics_t             m;
      logic [ERR_W-1:0]     ma;
      logic [ERR_W-1:0]     mb;
      logic [ERR_W-1:0]     d;
      logic [2*ERR_W-1:0]   full_sq;
      logic [SUM_W:0]       total;
      logic                 special;
      if (restart) clear_totals();
      pair_cnt = sat_inc(pair_cnt);
      special = (a[14:10] == 5'd31) || (b[14:10] == 5'd31);
      d = '0;
      if (special) begin
        nonfin_cnt = sat_inc(nonfin_cnt);
      end else begin
        ma = decode_half(a);
        mb = decode_half(b);
        if (a[15] == b[15]) d = (ma >= mb) ? ma - mb : mb - ma;
        else d = ma + mb;
        full_sq = (2*ERR_W)'(d) * (2*ERR_W)'(d);
        total = {1'b0, sq_acc} + (SUM_W+1)'(full_sq >> LO_W);
        sq_acc = total[SUM_W] ? '1 : total[SUM_W-1:0];
        if (d > peak_err) peak_err = d;
        if (d > tolerance) over_cnt = sat_inc(over_cnt);
      end
      m.seen      = pair_cnt[OUT_CNT_W-1:0];
      m.nonfin    = nonfin_cnt[OUT_CNT_W-1:0];
      m.over      = over_cnt[OUT_CNT_W-1:0];
      m.sq_sum    = sq_acc;
      m.peak      = peak_err;
      m.err       = d;
      m.nonfinite = special;
      expected_q.push_back(m);
    endfunction

    function void flag(input string what, input logic [63:0] e, input logic [63:0] g);
      fails++;
      if (reported < 10) begin
        reported++;
        $display("mismatch %s: expected %0h got %0h", what, e, g);
      end
    endfunction

    function void field_ok(input string what, input logic [63:0] e, input logic [63:0] g);
      if (g !== e) flag(what, e, g);
    endfunction

    function void check_metrics(input logic [OUT_TDATA_W-1:0] d, input logic flag_bit);
      metrics_t m;
      if (expected_q.size() == 0) begin
        flag("result with nothing outstanding", 64'd0, 64'd0);
        return;
      end
      m = expected_q.pop_front();
      field_ok("values_seen", 64'(m.seen), 64'(d[OFS_SEEN +: OUT_CNT_W]));
      field_ok("nonfinite_count", 64'(m.nonfin), 64'(d[OFS_NONFIN +: OUT_CNT_W]));
      field_ok("over_tolerance", 64'(m.over), 64'(d[OFS_OVER +: OUT_CNT_W]));
      field_ok("squared_error_sum", m.sq_sum, d[OFS_SUM +: SUM_W]);
      field_ok("largest_error", 64'(m.peak), 64'(d[OFS_PEAK +: ERR_W]));
      field_ok("pair_error", 64'(m.err), 64'(d[OFS_ERR +: ERR_W]));
      field_ok("pair_nonfinite", 64'(m.nonfinite), 64'(flag_bit));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we;
  logic [TOL_W-1:0]       cfg_wdata;

  // idling knobs, percent of cycles
  int send_idle_pct;
  int stall_pct;

  metrics_scoreboard sb = new();

  half_float_error_metrics_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // reference_half, candidate_half, restart, zero pad
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // values_seen .. pair_error, zero pad
    .out_tuser  (out_tuser),    // pair_nonfinite
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver: back-pressure decided afresh on every falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Both channels sampled at the rising edge; the input is noted before the
  // result is checked so ordering holds whatever the latency.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_pair(in_tdata[IN_OFS_REF +: HALF_W], in_tdata[IN_OFS_CAND +: HALF_W],
                     in_tdata[IN_OFS_RESTART]);
      end
      if (out_tvalid && out_tready) begin
        sb.check_metrics(out_tdata, out_tuser);
      end
    end
  end

  // Random finite half: exponent never 31.
  function automatic logic [HALF_W-1:0] finite_half();
    return {1'($urandom_range(1)), 5'($urandom_range(30)), 10'($urandom)};
  endfunction

  // Edge values of the format, random sign.
  function automatic logic [HALF_W-1:0] special_half();
    logic [HALF_W-1:0] h;
    case ($urandom_range(8))
      0: h = 16'h7C00;                                    // infinity
      1: h = {1'b0, 5'd31, 10'($urandom_range(1023, 1))}; // NaN
      2: h = 16'h0000;
      3: h = 16'h0001;                                    // smallest subnormal
      4: h = 16'h03FF;                                    // largest subnormal
      5: h = 16'h0400;                                    // smallest normal
      6: h = 16'h7BFF;                                    // largest finite
      7: h = 16'h3C00;                                    // one
      default: h = 16'h7FFF;
    endcase
    h[15] = 1'($urandom_range(1));
    return h;
  endfunction

  task automatic random_pair(output logic [HALF_W-1:0] a, output logic [HALF_W-1:0] b,
                             output logic rs);
    int pick;
    int delta;
    pick = $urandom_range(99);
    rs = ($urandom_range(39) == 0);
    if (pick < 20) begin
      // raw noise, nonfinite now and then
      a = 16'($urandom);
      b = 16'($urandom);
    end else if (pick < 45) begin
      // close pair, errors around typical tolerances
      a = finite_half();
      delta = $urandom_range(32) - 16;
      b = 16'(int'(a) + delta);
    end else if (pick < 60) begin
      // one side zero of either sign
      a = finite_half();
      b = {1'($urandom_range(1)), 15'd0};
      if ($urandom_range(1)) {a, b} = {b, a};
    end else if (pick < 70) begin
      // huge values of opposite sign
      a = {1'b0, 5'd30, 10'($urandom)};
      b = {1'b1, 5'd30, 10'($urandom)};
    end else if (pick < 80) begin
      a = special_half();
      b = special_half();
    end else begin
      a = finite_half();
      b = finite_half();
    end
  endtask

  // Present one pair, wait for acceptance; enters and leaves at a falling edge.
  task automatic send_pair(input logic [HALF_W-1:0] a, input logic [HALF_W-1:0] b,
                           input logic rs);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_OFS_REF +: HALF_W]  = a;
    word[IN_OFS_CAND +: HALF_W] = b;
    word[IN_OFS_RESTART]        = rs;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drain everything outstanding, then write the tolerance while idle.
  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sb.set_tolerance(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One phase of random traffic with a burst of maximal errors somewhere in
  // it, long enough without restart to drive the square sum into saturation.
  task automatic run_phase(input int n, input int idle, input int stall);
    int burst_at;
    logic [HALF_W-1:0] a;
    logic [HALF_W-1:0] b;
    logic rs;
    send_idle_pct = idle;
    stall_pct = stall;
    burst_at = $urandom_range(n - 101);
    for (int i = 0; i < n; i++) begin
      if (i >= burst_at && i < burst_at + 100) begin
        rs = 1'b0;
        if (i % 2 == 0) begin
          a = 16'h7BFF;
          b = 16'hFBFF;
        end else begin
          a = {1'b1, 5'd30, 10'($urandom)};
          b = {1'b0, 5'd30, 10'($urandom)};
        end
      end else begin
        random_pair(a, b, rs);
      end
      send_pair(a, b, rs);
    end
  endtask

  // Directed pairs: zeros of both signs, format extremes, infinities and NaNs,
  // the tolerance boundary (equal, not over; one above, over) and restarts.
  localparam int N_DIR = 18;
  localparam logic [HALF_W-1:0] DIR_A [N_DIR] = '{
    16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h7BFF, 16'hFBFF,
    16'h7C00, 16'h0000, 16'h7E00, 16'hFFFF, 16'h1419, 16'h1400,
    16'h3C00, 16'h7BFF, 16'hBC00, 16'h4000, 16'h0000, 16'h7BFF};
  localparam logic [HALF_W-1:0] DIR_B [N_DIR] = '{
    16'h0000, 16'h0000, 16'h8001, 16'h0400, 16'hFBFF, 16'h7BFF,
    16'h0000, 16'hFC00, 16'h3C00, 16'hFFFF, 16'h0007, 16'h818A,
    16'h3C01, 16'h0000, 16'h3C00, 16'h3C00, 16'h0000, 16'h7BFF};
  localparam logic [N_DIR-1:0] DIR_RESTART = 18'b10_0000_0010_0000_0001;

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part runs at the reset tolerance
    for (int i = 0; i < N_DIR; i++) begin
      send_pair(DIR_A[i], DIR_B[i], DIR_RESTART[i]);
    end

    // random phases: tolerance and idling change between them
    write_tolerance(TOL_W'(16777));
    run_phase(320, 0, 0);
    write_tolerance('0);
    run_phase(320, 80, 0);
    write_tolerance('1);
    run_phase(320, 0, 80);
    write_tolerance(TOL_W'(41'h100000));
    run_phase(320, 31, 31);
    write_tolerance(TOL_W'({$urandom_range(511), $urandom}));
    run_phase(320, 0, 0);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
